@@ design/r8ts_pkg.sv @@
// r8ts_pkg: types, codes and helpers for the radix-8 trie set.
// No dependencies; the top level and both testbench files import this package.
`default_nettype none
package r8ts_pkg;

    localparam int NODE_GROUPS_DEF = 1024;
    localparam int FANOUT          = 8;
    localparam int DIGIT_W         = 3;
    localparam int KEY_W           = 24;
    localparam int COUNT_W         = 14;
    localparam int LAST_DIGIT      = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3fff;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_LEAF  = 2'd1;
    localparam logic [1:0] KIND_INNER = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] load;
    } t_node;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] element_count;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EVAL, S_SCAN, S_CLEAR, S_LINK, S_LEAF_OLD, S_LEAF_NEW, S_FIN
    } t_state;

    function automatic logic [DIGIT_W-1:0] digit(input logic [KEY_W-1:0] key,
                                                 input logic [3:0] d);
        logic [DIGIT_W-1:0] r;
        case (d)
            4'd0: r = key[23:21];
            4'd1: r = key[20:18];
            4'd2: r = key[17:15];
            4'd3: r = key[14:12];
            4'd4: r = key[11:9];
            4'd5: r = key[8:6];
            4'd6: r = key[5:3];
            4'd7: r = key[2:0];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage
`default_nettype wire

@@ design/r8ts_stream_if.sv @@
// r8ts_stream_if: valid/ready channel carrying one payload item.
// Payload type is a parameter; used with r8ts_pkg structs.
`default_nettype none
interface r8ts_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/radix8_trie_set.sv @@
// radix8_trie_set: top level, sequencer over the node RAM and one digit compare.
// Depends on r8ts_pkg, r8ts_stream_if and r8ts_ram.
//
//  channel | dir | payload
//  i_req   | in  | opcode (1), key (24)
//  o_rsp   | out | status (2), element_count (14)
//
// Each level descended reads the node RAM, whose read is registered (S_READ, then
// S_EVAL); the result then enters the output register in S_FIN. A split scans one
// digit at a time (S_SCAN), then per new group clears 8 slots (S_CLEAR) and links
// it (S_LINK), then writes 2 leaves (S_LEAF_OLD, S_LEAF_NEW).
// Reset empties the root and zeroes the group allocation counter and the count; no clearing pass.
// One item at a time; a finished result waits in the output register.
`default_nettype none
module radix8_trie_set
    import r8ts_pkg::*;
#(
    parameter int NODE_GROUPS = NODE_GROUPS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    r8ts_stream_if.sink   i_req,
    r8ts_stream_if.source o_rsp
);
    localparam int GIW = (NODE_GROUPS > 1) ? $clog2(NODE_GROUPS) : 1;
    localparam int AW  = GIW + DIGIT_W;
    localparam int GW  = $clog2(NODE_GROUPS + 1);

    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [KEY_W-1:0]   r_old, n_old;
    logic [3:0]         r_depth, n_depth;
    logic [3:0]         r_scan, n_scan;
    logic [AW-1:0]      r_slot, n_slot;
    logic               r_at_root, n_at_root;
    logic               r_oob, n_oob;
    logic [DIGIT_W-1:0] r_clr, n_clr;
    t_node              r_root, n_root;
    logic [GW-1:0]      r_groups, n_groups;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_status, n_status;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_node         w_wdata;
    logic [25:0]   w_rdata;
    t_node         w_node;
    logic [3:0]    w_need;
    logic [GIW-1:0] w_g;

    r8ts_ram #(.WIDTH(26), .DEPTH(NODE_GROUPS * FANOUT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign w_g         = r_groups[GIW-1:0];
    assign w_need      = r_scan - r_depth + 4'd1;

    always_comb begin
        if (r_at_root) begin
            w_node = r_root;
        end else if (r_oob) begin
            w_node = '0;
        end else begin
            w_node = t_node'(w_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root      <= '{kind: KIND_EMPTY, load: '0};
            r_groups    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root      <= n_root;
            r_groups    <= n_groups;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_old     <= n_old;
        r_depth   <= n_depth;
        r_scan    <= n_scan;
        r_slot    <= n_slot;
        r_at_root <= n_at_root;
        r_oob     <= n_oob;
        r_clr     <= n_clr;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_old       = r_old;
        n_depth     = r_depth;
        n_scan      = r_scan;
        n_slot      = r_slot;
        n_at_root   = r_at_root;
        n_oob       = r_oob;
        n_clr       = r_clr;
        n_root      = r_root;
        n_groups    = r_groups;
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wdata     = '{kind: KIND_EMPTY, load: '0};

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.data.opcode;
                    n_key     = i_req.data.key;
                    n_depth   = '0;
                    n_at_root = 1'b1;
                    n_oob     = 1'b0;
                    n_status  = ST_OK;
                    n_state   = S_EVAL;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_node.kind == KIND_INNER) begin
                    if (r_depth == 4'd8) begin
                        n_status = (r_op == OP_FIND) ? ST_NOT_FOUND : ST_OK;
                        n_state  = S_FIN;
                    end else begin
                        n_slot    = {w_node.load[GIW-1:0], digit(r_key, r_depth)};
                        n_oob     = (w_node.load >= KEY_W'(NODE_GROUPS));
                        n_at_root = 1'b0;
                        n_depth   = r_depth + 4'd1;
                        n_state   = S_READ;
                    end
                end else if (r_op == OP_FIND) begin
                    n_status = (w_node.kind == KIND_LEAF && w_node.load == r_key)
                             ? ST_OK : ST_NOT_FOUND;
                    n_state  = S_FIN;
                end else if (w_node.kind != KIND_LEAF) begin
                    w_wdata = '{kind: KIND_LEAF, load: r_key};
                    if (r_at_root) begin
                        n_root = w_wdata;
                    end else begin
                        w_we = !r_oob;
                    end
                    n_count = sat_inc(r_count);
                    n_state = S_FIN;
                end else if (w_node.load == r_key) begin
                    n_state = S_FIN;
                end else begin
                    n_old   = w_node.load;
                    n_scan  = r_depth;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan < 4'(LAST_DIGIT) && digit(r_old, r_scan) == digit(r_key, r_scan)) begin
                    n_scan = r_scan + 4'd1;
                end else if ((GW+1)'(r_groups) + (GW+1)'(w_need) > (GW+1)'(NODE_GROUPS)) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_clr   = '0;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = {w_g, r_clr};
                n_clr   = r_clr + 1'b1;
                if (r_clr == DIGIT_W'(FANOUT - 1)) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                w_wdata = '{kind: KIND_INNER, load: KEY_W'(r_groups)};
                if (r_at_root) begin
                    n_root = w_wdata;
                end else begin
                    w_we = !r_oob;
                end
                if (r_depth < r_scan) begin
                    n_slot    = {w_g, digit(r_key, r_depth)};
                    n_at_root = 1'b0;
                    n_oob     = 1'b0;
                    n_depth   = r_depth + 4'd1;
                    n_groups  = r_groups + 1'b1;
                    n_clr     = '0;
                    n_state   = S_CLEAR;
                end else begin
                    n_state = S_LEAF_OLD;
                end
            end
            S_LEAF_OLD: begin
                w_we    = 1'b1;
                w_waddr = {w_g, digit(r_old, r_scan)};
                w_wdata = '{kind: KIND_LEAF, load: r_old};
                n_state = S_LEAF_NEW;
            end
            S_LEAF_NEW: begin
                w_we     = 1'b1;
                w_waddr  = {w_g, digit(r_key, r_scan)};
                w_wdata  = '{kind: KIND_LEAF, load: r_key};
                n_groups = r_groups + 1'b1;
                n_count  = sat_inc(r_count);
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: r_status, element_count: r_count};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_groups <= GW'(NODE_GROUPS))
        else $error("group pool overrun");
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != S_IDLE && r_state != S_FIN))
        else $error("node write outside an operation");
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("element count decreased");
    a_full_keeps_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_status == ST_FULL) |=> $stable(r_groups))
        else $error("pool changed on a full insert");
`endif

endmodule
`default_nettype wire

@@ design/r8ts_ram.sv @@
// r8ts_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module r8ts_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ verif/r8ts_tb_pkg.sv @@
// r8ts_tb_pkg: prediction of the radix-8 trie set and the result scoreboard.
// Depends on r8ts_pkg.
package r8ts_tb_pkg;
    import r8ts_pkg::*;

    localparam int POOL_GROUPS = NODE_GROUPS_DEF;
    localparam int POOL_NODES  = POOL_GROUPS * FANOUT;

    class trie_scoreboard;
        t_node      root;
        t_node      pool[POOL_NODES];
        int         groups_taken;
        logic [COUNT_W-1:0] keys_held;
        t_rsp       pending[$];
        int         mismatches;

        function new();
            root = '{KIND_EMPTY, '0};
            foreach (pool[i]) pool[i] = '{KIND_EMPTY, '0};
            groups_taken = 0;
            keys_held = '0;
            mismatches = 0;
        endfunction

        function t_node read_node(int slot);
            if (slot < 0) return root;
            if (slot >= POOL_NODES) return '{KIND_EMPTY, '0};
            return pool[slot];
        endfunction

        function void write_node(int slot, t_node n);
            if (slot < 0) root = n;
            else if (slot < POOL_NODES) pool[slot] = n;
        endfunction

        function logic [2:0] key_digit(logic [KEY_W-1:0] k, int d);
            if (d > LAST_DIGIT) return '0;
            return k[(LAST_DIGIT - d) * 3 +: 3];
        endfunction

        function void note_request(t_req req);
            t_rsp  r;
            t_node n;
            t_node leaf_old;
            int    slot;
            int    d;
            int    split_at;
            int    g;
            logic [KEY_W-1:0] old_key;
            r.status = ST_OK;
            slot = -1;
            for (d = 0; d <= 8; d++) begin
                n = read_node(slot);
                if (n.kind == KIND_INNER) begin
                    slot = (n.load >= POOL_GROUPS) ? POOL_NODES
                         : int'(n.load) * FANOUT + key_digit(req.key, d);
                    continue;
                end
                if (req.opcode == OP_FIND) begin
                    r.status = (n.kind == KIND_LEAF && n.load == req.key) ? ST_OK : ST_NOT_FOUND;
                    break;
                end
                if (n.kind != KIND_LEAF) begin
                    write_node(slot, '{KIND_LEAF, req.key});
                    keys_held = sat_inc(keys_held);
                    break;
                end
                if (n.load == req.key) break;
                old_key = n.load;
                split_at = d;
                while (split_at < 7 && key_digit(old_key, split_at) == key_digit(req.key, split_at))
                    split_at++;
                if (groups_taken + split_at - d + 1 > POOL_GROUPS) begin
                    r.status = ST_FULL;
                    break;
                end
                for (int j = d; j <= split_at; j++) begin
                    g = groups_taken++;
                    for (int c = 0; c < FANOUT; c++) write_node(g * FANOUT + c, '{KIND_EMPTY, '0});
                    write_node(slot, '{KIND_INNER, KEY_W'(g)});
                    if (j < split_at) begin
                        slot = g * FANOUT + key_digit(req.key, j);
                    end else begin
                        leaf_old = '{KIND_LEAF, old_key};
                        write_node(g * FANOUT + key_digit(old_key, split_at), leaf_old);
                        write_node(g * FANOUT + key_digit(req.key, split_at),
                                   '{KIND_LEAF, req.key});
                    end
                end
                keys_held = sat_inc(keys_held);
                break;
            end
            if (d > 8 && req.opcode == OP_FIND) r.status = ST_NOT_FOUND;
            r.element_count = keys_held;
            pending.push_back(r);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result status=%0d count=%0d",
                         $time, got.status, got.element_count);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.element_count !== want.element_count) begin
                $display("%0t element_count expected %0d actual %0d",
                         $time, want.element_count, got.element_count);
                mismatches++;
            end
        endfunction
    endclass
endpackage

@@ verif/radix8_trie_set_tb.sv @@
// radix8_trie_set_tb: drives inserts and finds through radix8_trie_set and checks results.
// Depends on r8ts_pkg, r8ts_stream_if, r8ts_tb_pkg and the design.
module radix8_trie_set_tb;
    import r8ts_pkg::*;
    import r8ts_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    logic [KEY_W-1:0] recent_keys[$];
    trie_scoreboard sb;

    r8ts_stream_if #(.t_payload(t_req)) req_ch ();
    r8ts_stream_if #(.t_payload(t_rsp)) rsp_ch ();

    radix8_trie_set i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.data);
            results_seen <= results_seen + 1;
        end
        if (i_rst_n)
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_item(logic op, logic [KEY_W-1:0] k);
        t_req req;
        req.opcode = op;
        req.key = k;
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= req;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(req);
        items_sent++;
        if (recent_keys.size() > 40) void'(recent_keys.pop_front());
        recent_keys.push_back(k);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int m;
        m = $urandom_range(9);
        k = KEY_W'($urandom);
        if (m < 3 && recent_keys.size() > 0)
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        else if (m < 6 && recent_keys.size() > 0)
            k = recent_keys[$urandom_range(recent_keys.size() - 1)] ^ KEY_W'(1 << $urandom_range(23));
        return k;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: empty find, extremes, duplicates, deepest split, near keys
        send_item(OP_FIND,   24'h000000);
        send_item(OP_INSERT, 24'h000000);
        send_item(OP_INSERT, 24'h000000);
        send_item(OP_FIND,   24'h000000);
        send_item(OP_INSERT, 24'h000001);
        send_item(OP_INSERT, 24'hffffff);
        send_item(OP_INSERT, 24'hfffffe);
        send_item(OP_FIND,   24'hfffffe);
        send_item(OP_FIND,   24'hfffff0);
        send_item(OP_FIND,   24'h000002);
        send_item(OP_INSERT, 24'h800000);
        send_item(OP_INSERT, 24'h400000);
        send_item(OP_INSERT, 24'h555555);
        send_item(OP_INSERT, 24'haaaaaa);
        send_item(OP_FIND,   24'haaaaaa);
        send_item(OP_FIND,   24'h555554);
        send_item(OP_INSERT, 24'h000008);
        send_item(OP_FIND,   24'h000009);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 47) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 47) : 0;
            for (int n = 0; n < 120; n++)
                send_item($urandom_range(99) < 55 ? OP_INSERT : OP_FIND, pick_key());
        end
        // exhaust the pool with deep splits
        send_idle = 0;
        recv_stall = 0;
        for (int n = 0; n < 120; n++) begin
            logic [KEY_W-1:0] xk;
            xk = KEY_W'($urandom);
            send_item(OP_INSERT, xk);
            send_item(OP_INSERT, xk ^ 24'h000001);
        end
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d inserts/finds in four idle/stall phases, plus a pool-exhaust run;",
                 items_sent);
        $display("%0d results checked, %0d keys held at the end.", results_seen, sb.keys_held);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
